// ===== sv/mtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mtu_pkg
// Types and constants shared by the MIDI to UMP note tracker modules.
// ----------------------------------------------------------------------------
package mtu_pkg;

    localparam int MAP_WORDS  = 32;
    localparam int MAP_IDX_W  = 5;
    localparam int PROD_W     = 96;
    localparam int DIV_CNT_W  = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [1:0] OP_MESSAGE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOM = 1'b1;

    localparam logic [3:0] UMP_TYPE_CV  = 4'h2;
    localparam logic [3:0] UMP_GROUP    = 4'h0;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;

    typedef enum logic [1:0] {
        K_MSG = 2'd0,
        K_BAD = 2'd1,
        K_REL = 2'd2,
        K_CLR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MO_NONE = 2'd0,
        MO_SET  = 2'd1,
        MO_CLR  = 2'd2
    } t_map_op;

    typedef struct packed {
        t_kind                kind;
        t_map_op              map_op;
        logic [MAP_IDX_W-1:0] map_idx;
        logic [5:0]           note_bit;
        logic [31:0]          word;
        logic                 time_pos;
        logic [63:0]          time_val;
        logic [3:0]           rel_ch;
        logic                 rel_bank;
    } t_cmd;

endpackage

// ===== sv/mtu_if.sv =====
// ----------------------------------------------------------------------------
// mtu_if
// Valid/ready channel interfaces: input items, result items, config writes.
// ----------------------------------------------------------------------------
interface mtu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  byte_count;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic signed [63:0] host_time_ns;
    logic [63:0] release_stamp;
    logic [3:0]  release_channel;
    logic        release_bank;

    modport source (
        output valid, operation, byte_count, status_byte, data_one, data_two,
               host_time_ns, release_stamp, release_channel, release_bank,
        input  ready
    );
    modport sink (
        input  valid, operation, byte_count, status_byte, data_one, data_two,
               host_time_ns, release_stamp, release_channel, release_bank,
        output ready
    );
endinterface

interface mtu_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] ump_word;
    logic [63:0] stamp_ticks;
    logic [63:0] newest_stamp;
    logic        last_of_run;

    modport source (
        output valid, accepted, ump_word, stamp_ticks, newest_stamp, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, accepted, ump_word, stamp_ticks, newest_stamp, last_of_run,
        output ready
    );
endinterface

interface mtu_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mtu_fifo.sv =====
// ----------------------------------------------------------------------------
// mtu_fifo
// Small command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module mtu_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output mtu_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import mtu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== sv/mtu_front.sv =====
// ----------------------------------------------------------------------------
// mtu_front
// Accepts input items, classifies them and builds queue commands.
// ----------------------------------------------------------------------------
module mtu_front (
    mtu_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output mtu_pkg::t_cmd o_cmd
);
    import mtu_pkg::*;

    logic       cnt_ok;
    logic [7:0] b1, b2;
    logic [6:0] note;
    logic [3:0] st;

    assign i_in.ready = !i_full;
    // unused operation code is taken and dropped
    assign o_push = i_in.valid && !i_full && (i_in.operation != OP_UNUSED);

    assign cnt_ok = (i_in.byte_count >= 3'd1) && (i_in.byte_count <= 3'd3);
    assign b1     = (i_in.byte_count >= 3'd2) ? i_in.data_one : 8'd0;
    assign b2     = (i_in.byte_count == 3'd3) ? i_in.data_two : 8'd0;
    assign note   = b1[6:0];
    assign st     = i_in.status_byte[7:4];

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = K_CLR;
        o_cmd.map_op   = MO_NONE;
        o_cmd.word     = {UMP_TYPE_CV, UMP_GROUP, i_in.status_byte, b1, b2};
        o_cmd.note_bit = note[5:0];
        o_cmd.rel_ch   = i_in.release_channel;
        o_cmd.rel_bank = i_in.release_bank;
        if (st == ST_NOTE_ON && b2 != 8'd0) begin
            o_cmd.map_op = MO_SET;
        end else if (st == ST_NOTE_ON || st == ST_NOTE_OFF) begin
            o_cmd.map_op = MO_CLR;
        end
        priority if (i_in.operation == OP_MESSAGE) begin
            o_cmd.kind     = cnt_ok ? K_MSG : K_BAD;
            o_cmd.map_idx  = {i_in.status_byte[3:0], note[6]};
            o_cmd.time_val = i_in.host_time_ns;
            o_cmd.time_pos = !i_in.host_time_ns[63] && (i_in.host_time_ns != 64'sd0);
        end else if (i_in.operation == OP_RELEASE) begin
            o_cmd.kind     = K_REL;
            o_cmd.map_idx  = {i_in.release_channel, i_in.release_bank};
            o_cmd.time_val = i_in.release_stamp;
        end else begin
            o_cmd.kind = K_CLR;
        end
    end

endmodule

// ===== sv/mtu_div.sv =====
// ----------------------------------------------------------------------------
// mtu_div
// Tick conversion: ns*denom in two 32x32 products, then a bit-serial
// restoring division by numer over 96 steps, saturated to 64 bits.
// ----------------------------------------------------------------------------
module mtu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_ns,
    input  logic [31:0] i_numer,
    input  logic [31:0] i_denom,
    output logic        o_done,
    output logic [63:0] o_quot
);
    import mtu_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MLO  = 5'b00010,
        D_MHI  = 5'b00100,
        D_SUM  = 5'b01000,
        D_DIV  = 5'b10000
    } t_dstate;

    t_dstate              r_state, n_state;
    logic [63:0]          r_a, n_a;
    logic [31:0]          r_d, n_d;
    logic [31:0]          r_n, n_n;
    logic [63:0]          r_plo, n_plo;
    logic [63:0]          r_phi, n_phi;
    logic [PROD_W-1:0]    r_dvd, n_dvd;
    logic [31:0]          r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [32:0]          trial;
    logic                 ge;

    assign trial  = {r_rem, r_dvd[PROD_W-1]};
    assign ge     = (trial >= {1'b0, r_n});
    assign o_done = r_done;
    assign o_quot = (r_dvd[PROD_W-1:64] != '0) ? '1 : r_dvd[63:0];

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_d     = r_d;
        n_n     = r_n;
        n_plo   = r_plo;
        n_phi   = r_phi;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_a     = i_ns;
                    n_d     = i_denom;
                    // zero numerator counts as one
                    n_n     = (i_numer == 32'd0) ? 32'd1 : i_numer;
                    n_state = D_MLO;
                end
            end
            D_MLO: begin
                n_plo   = 64'(r_a[31:0]) * 64'(r_d);
                n_state = D_MHI;
            end
            D_MHI: begin
                n_phi   = 64'(r_a[63:32]) * 64'(r_d);
                n_state = D_SUM;
            end
            D_SUM: begin
                n_dvd   = {r_phi, 32'd0} + {32'd0, r_plo};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = D_DIV;
            end
            D_DIV: begin
                n_rem = ge ? 32'(trial - {1'b0, r_n}) : trial[31:0];
                n_dvd = {r_dvd[PROD_W-2:0], ge};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(PROD_W - 1)) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_d   <= n_d;
        r_n   <= n_n;
        r_plo <= n_plo;
        r_phi <= n_phi;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

endmodule

// ===== sv/mtu_back.sv =====
// ----------------------------------------------------------------------------
// mtu_back
// Executes queued commands: note map updates, tick stamps, release scans,
// and the result output register.
// ----------------------------------------------------------------------------
module mtu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  mtu_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [31:0]   i_numer,
    input  logic [31:0]   i_denom,
    mtu_out_if.source     o_out
);
    import mtu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WAIT = 4'b0010,
        S_PUT  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_map [MAP_WORDS];
    logic [63:0] r_latest, n_latest;
    logic [31:0] r_word, n_word;
    logic [63:0] r_stamp, n_stamp;
    logic [63:0] r_bits, n_bits;
    logic [5:0]  r_cnt, n_cnt;
    logic [3:0]  r_ch, n_ch;
    logic        r_bank, n_bank;

    logic        r_ov;
    logic        r_oacc;
    logic [31:0] r_oword;
    logic [63:0] r_ostamp;
    logic [63:0] r_onewest;
    logic        r_olast;

    logic        slot_free;
    logic        emit;
    logic        e_acc, e_last;
    logic [31:0] e_word;
    logic [63:0] e_stamp, e_newest;
    logic        map_clear, map_we;
    logic [63:0] row, n_row, new_latest;
    logic        div_start, div_done;
    logic [63:0] div_quot;

    mtu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ns    (i_cmd.time_val),
        .i_numer (i_numer),
        .i_denom (i_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign slot_free  = !r_ov || o_out.ready;
    assign row        = r_map[i_cmd.map_idx];
    assign new_latest = (r_stamp > r_latest) ? r_stamp : r_latest;

    always_comb begin
        n_state   = r_state;
        n_latest  = r_latest;
        n_word    = r_word;
        n_stamp   = r_stamp;
        n_bits    = r_bits;
        n_cnt     = r_cnt;
        n_ch      = r_ch;
        n_bank    = r_bank;
        o_pop     = 1'b0;
        div_start = 1'b0;
        map_clear = 1'b0;
        map_we    = 1'b0;
        n_row     = row;
        emit      = 1'b0;
        e_acc     = 1'b1;
        e_word    = r_word;
        e_stamp   = r_stamp;
        e_newest  = r_latest;
        e_last    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        K_CLR: begin
                            o_pop     = 1'b1;
                            map_clear = 1'b1;
                        end
                        K_BAD: begin
                            if (slot_free) begin
                                o_pop   = 1'b1;
                                emit    = 1'b1;
                                e_acc   = 1'b0;
                                e_word  = '0;
                                e_stamp = '0;
                            end
                        end
                        K_MSG: begin
                            o_pop  = 1'b1;
                            n_word = i_cmd.word;
                            unique case (i_cmd.map_op)
                                MO_SET: begin
                                    map_we = 1'b1;
                                    n_row  = row | (64'd1 << i_cmd.note_bit);
                                end
                                MO_CLR: begin
                                    map_we = 1'b1;
                                    n_row  = row & ~(64'd1 << i_cmd.note_bit);
                                end
                                MO_NONE: map_we = 1'b0;
                                default: map_we = 1'b0;
                            endcase
                            if (i_cmd.time_pos) begin
                                div_start = 1'b1;
                                n_state   = S_WAIT;
                            end else begin
                                n_stamp = '0;
                                n_state = S_PUT;
                            end
                        end
                        K_REL: begin
                            o_pop   = 1'b1;
                            n_bits  = row;
                            n_cnt   = '0;
                            n_ch    = i_cmd.rel_ch;
                            n_bank  = i_cmd.rel_bank;
                            n_stamp = i_cmd.time_val;
                            n_state = S_SCAN;
                        end
                        default: o_pop = 1'b0;
                    endcase
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    n_stamp = div_quot;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    e_newest = new_latest;
                    n_latest = new_latest;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                // row shifts down one note a step, the low bit is the current note
                e_word = {UMP_TYPE_CV, UMP_GROUP, ST_NOTE_OFF, r_ch,
                          1'b0, r_bank, r_cnt, 8'd0};
                e_last = (r_bits[63:1] == 63'd0);
                if (r_bits == 64'd0) begin
                    n_state = S_IDLE;
                end else if (!r_bits[0] || slot_free) begin
                    emit   = r_bits[0];
                    n_bits = {1'b0, r_bits[63:1]};
                    n_cnt  = r_cnt + 6'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_latest <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < MAP_WORDS; i++) begin
                r_map[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_latest <= n_latest;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (map_clear) begin
                for (int i = 0; i < MAP_WORDS; i++) begin
                    r_map[i] <= '0;
                end
            end else if (map_we) begin
                r_map[i_cmd.map_idx] <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_stamp <= n_stamp;
        r_bits  <= n_bits;
        r_cnt   <= n_cnt;
        r_ch    <= n_ch;
        r_bank  <= n_bank;
        if (emit) begin
            r_oacc    <= e_acc;
            r_oword   <= e_word;
            r_ostamp  <= e_stamp;
            r_onewest <= e_newest;
            r_olast   <= e_last;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.accepted     = r_oacc;
    assign o_out.ump_word     = r_oword;
    assign o_out.stamp_ticks  = r_ostamp;
    assign o_out.newest_stamp = r_onewest;
    assign o_out.last_of_run  = r_olast;

endmodule

// ===== sv/midi_to_ump_note_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// midi_to_ump_note_tracker_unit
// MIDI 1.0 to type-2 UMP converter with tick stamps and an active-note map.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  i_in     | in  | operation, message bytes, ns time, release fields
//  o_out    | out | accepted, ump_word, stamp_ticks, newest_stamp, last_of_run
//  i_cfg    | in  | index (0 numer, 1 denom), 32-bit data; always ready
//
// a message in the back goes through two 32x32 products, one sum and 96 steps
// of the bit-serial divider; a time at or below zero skips them
// a release scans one note of the bank per cycle, holding while the result
// slot is full, and takes one more step to see the row empty
// clear and rejected items need no divide or scan; the front keeps taking items
// until the QUEUE_DEPTH command queue fills
// reset is synchronous, active low, and empties the note map at once
// ----------------------------------------------------------------------------
module midi_to_ump_note_tracker_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtu_in_if.sink    i_in,
    mtu_out_if.source o_out,
    mtu_cfg_if.sink   i_cfg
);
    import mtu_pkg::*;

    logic [31:0] r_numer;
    logic [31:0] r_denom;
    logic        push, pop, full, empty;
    t_cmd        cmd_in, cmd_head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numer <= 32'd1;
            r_denom <= 32'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_NUMER: r_numer <= i_cfg.data;
                CFG_DENOM: r_denom <= i_cfg.data;
                default:   r_numer <= r_numer;
            endcase
        end
    end

    mtu_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (cmd_in)
    );

    mtu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_full  (full),
        .o_empty (empty)
    );

    mtu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (cmd_head),
        .o_pop   (pop),
        .i_numer (r_numer),
        .i_denom (r_denom),
        .o_out   (o_out)
    );

endmodule

// ===== sv/mtu_checker.sv =====
// ----------------------------------------------------------------------------
// mtu_assert
// Port-level checks on the result channel of the note tracker.
// ----------------------------------------------------------------------------
module mtu_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_accepted,
    input logic [31:0] i_ump_word,
    input logic [63:0] i_stamp_ticks,
    input logic [63:0] i_newest_stamp,
    input logic        i_last_of_run
);
    import mtu_pkg::*;

    logic [63:0] r_prev_newest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_newest <= '0;
        end else if (i_valid && i_ready) begin
            r_prev_newest <= i_newest_stamp;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_ump_word))
        else $error("result dropped or changed while stalled");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_accepted |->
            i_ump_word == 32'd0 && i_stamp_ticks == 64'd0 && i_last_of_run)
        else $error("rejected result is not clean");

    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_accepted |-> i_ump_word[31:24] == {UMP_TYPE_CV, UMP_GROUP})
        else $error("accepted word is not type 2 group 0");

    a_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_newest_stamp >= r_prev_newest)
        else $error("newest stamp went backwards");

endmodule

bind midi_to_ump_note_tracker_unit mtu_assert u_mtu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_accepted     (o_out.accepted),
    .i_ump_word     (o_out.ump_word),
    .i_stamp_ticks  (o_out.stamp_ticks),
    .i_newest_stamp (o_out.newest_stamp),
    .i_last_of_run  (o_out.last_of_run)
);
